### design/dap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dap_pkg
// Shared types and constants for the deadline aware path selector.
// ----------------------------------------------------------------------------
package dap_pkg;

  localparam int MAX_PATHS = 16;
  localparam int POS_W     = $clog2(MAX_PATHS + 1);
  localparam int IDX_W     = 4;
  localparam int RTT_W     = 32;
  localparam int SCORE_W   = RTT_W + 1;
  localparam int TIME_W    = 64;
  localparam int MARGIN_W  = 20;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(1000);

  localparam logic [1:0] KIND_DEFAULT  = 2'd0;
  localparam logic [1:0] KIND_FEASIBLE = 2'd1;
  localparam logic [1:0] KIND_FALLBACK = 2'd2;

  localparam logic [0:0] REG_DELAY_MARGIN = 1'b0;

  typedef struct packed {
    logic [RTT_W-1:0]  rtt_us;
    logic              demoted;
    logic [31:0]       in_flight_bytes;
    logic [31:0]       window_bytes;
    logic [TIME_W-1:0] now_us;
    logic [TIME_W-1:0] deadline_at_us;
    logic              deadline_on;
    logic              multipath_on;
    logic              last;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] chosen_path;
    logic [1:0]       selection_kind;
  } rsp_t;

  typedef struct packed {
    logic               feasible;
    logic [SCORE_W-1:0] score;
  } path_eval_t;

endpackage

### design/dap_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dap_cfg
// APB register file holding the delay margin.
// ----------------------------------------------------------------------------
module dap_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dap_pkg::APB_AW-1:0]    paddr,
  input  logic [dap_pkg::APB_DW-1:0]    pwdata,
  output logic [dap_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output logic [dap_pkg::MARGIN_W-1:0]  delay_margin_us
);

  logic       reg_sel;
  logic [0:0] reg_index;

  assign reg_index = paddr[dap_pkg::APB_AW-1 -: 1];
  assign reg_sel   = (reg_index == dap_pkg::REG_DELAY_MARGIN);
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_margin_us <= dap_pkg::MARGIN_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      delay_margin_us <= pwdata[dap_pkg::MARGIN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = dap_pkg::APB_DW'(delay_margin_us);
    end
  end

endmodule

### design/dap_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dap_eval
// Per-record feasibility test against the deadline and path score.
// ----------------------------------------------------------------------------
module dap_eval (
  input  dap_pkg::req_t                 item,
  input  logic [dap_pkg::MARGIN_W-1:0]  delay_margin_us,
  output dap_pkg::path_eval_t           result
);

  logic [dap_pkg::TIME_W:0]    left;
  logic [dap_pkg::SCORE_W-1:0] need;

  always_comb begin
    left = {1'b0, item.deadline_at_us} - {1'b0, item.now_us};
    need = dap_pkg::SCORE_W'(item.rtt_us >> 1) + dap_pkg::SCORE_W'(delay_margin_us);
    result.feasible = !item.demoted && !left[dap_pkg::TIME_W] &&
                      (dap_pkg::TIME_W'(need) < left[dap_pkg::TIME_W-1:0]);
    if (item.in_flight_bytes >= item.window_bytes) begin
      result.score = {item.rtt_us, 1'b0};
    end else begin
      result.score = {1'b0, item.rtt_us};
    end
  end

endmodule

### design/dap_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dap_track
// Running best and fallback tracking per request, and the result register.
// ----------------------------------------------------------------------------
module dap_track (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  dap_pkg::req_t        item,
  input  dap_pkg::path_eval_t  eval,
  output logic                 advance,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output dap_pkg::rsp_t        rsp
);

  logic [dap_pkg::POS_W-1:0]   position, position_next;
  logic                        found_feasible, found_feasible_next;
  logic [dap_pkg::SCORE_W-1:0] low_score, low_score_next;
  logic [dap_pkg::IDX_W-1:0]   best_index, best_index_next;
  logic [dap_pkg::RTT_W-1:0]   fallback_rtt, fallback_rtt_next;
  logic [dap_pkg::IDX_W-1:0]   fallback_index, fallback_index_next;
  logic [dap_pkg::IDX_W-1:0]   idx;
  dap_pkg::rsp_t               rsp_next;

  assign advance = item_valid && (!item.last || !rsp_valid || !rsp_stall);
  assign idx     = dap_pkg::IDX_W'(position);

  always_comb begin
    position_next       = position;
    found_feasible_next = found_feasible;
    low_score_next      = low_score;
    best_index_next     = best_index;
    fallback_rtt_next   = fallback_rtt;
    fallback_index_next = fallback_index;
    if (position < dap_pkg::POS_W'(dap_pkg::MAX_PATHS)) begin
      if (eval.feasible && (eval.score < low_score)) begin
        low_score_next      = eval.score;
        best_index_next     = idx;
        found_feasible_next = 1'b1;
      end
      if (position == '0) begin
        fallback_rtt_next   = item.rtt_us;
        fallback_index_next = '0;
      end else if (!item.demoted && (item.rtt_us < fallback_rtt)) begin
        fallback_rtt_next   = item.rtt_us;
        fallback_index_next = idx;
      end
      position_next = position + 1'b1;
    end
    if (!item.deadline_on || !item.multipath_on) begin
      rsp_next.chosen_path    = '0;
      rsp_next.selection_kind = dap_pkg::KIND_DEFAULT;
    end else if (found_feasible_next) begin
      rsp_next.chosen_path    = best_index_next;
      rsp_next.selection_kind = dap_pkg::KIND_FEASIBLE;
    end else begin
      rsp_next.chosen_path    = fallback_index_next;
      rsp_next.selection_kind = dap_pkg::KIND_FALLBACK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      found_feasible <= 1'b0;
      low_score      <= '1;
      best_index     <= '0;
      fallback_rtt   <= '0;
      fallback_index <= '0;
    end else if (advance) begin
      if (item.last) begin
        position       <= '0;
        found_feasible <= 1'b0;
        low_score      <= '1;
        best_index     <= '0;
        fallback_rtt   <= '0;
        fallback_index <= '0;
      end else begin
        position       <= position_next;
        found_feasible <= found_feasible_next;
        low_score      <= low_score_next;
        best_index     <= best_index_next;
        fallback_rtt   <= fallback_rtt_next;
        fallback_index <= fallback_index_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance && item.last) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last) begin
      rsp <= rsp_next;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    position <= dap_pkg::POS_W'(dap_pkg::MAX_PATHS))
    else $error("position beyond path limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (advance && item.last) |=> (position == '0 && !found_feasible))
    else $error("request state not cleared after last record");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(advance && item.last))
    else $error("result without a last record");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.selection_kind == dap_pkg::KIND_DEFAULT ||
                   rsp.selection_kind == dap_pkg::KIND_FEASIBLE ||
                   rsp.selection_kind == dap_pkg::KIND_FALLBACK))
    else $error("illegal selection kind");

  a_best_idle: assert property (@(posedge clk) disable iff (rst)
    !found_feasible |-> (low_score == '1))
    else $error("low score set without a feasible path");

endmodule

### design/deadline_aware_path_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_aware_path_select
// Picks a path for a request from a run of path records against a deadline.
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid / req_stall / req) carries one path record per
//   request beat; req.last marks the final record of a request.
//   rsp channel (rsp_valid / rsp_stall / rsp) carries one result per request.
//   the APB port holds the delay margin at byte address 0.
// timing:
//   one record is taken every cycle while req_stall is low. a record is evaluated
//   while it sits in the input register and folded into the running best and fallback at the
//   next edge; the result is registered in the output register as the last record advances.
// reset:
//   rst clears the request tracking and sets the margin to 1000 us.
// stall:
//   a waiting result holds in the output register; records that are not last
//   keep flowing, and a last record waits in the input register until the
//   output register frees, stalling req only then.
// ----------------------------------------------------------------------------
module deadline_aware_path_select (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  dap_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output dap_pkg::rsp_t               rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dap_pkg::APB_AW-1:0]  paddr,
  input  logic [dap_pkg::APB_DW-1:0]  pwdata,
  output logic [dap_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  logic                          item_valid;
  dap_pkg::req_t                 item;
  dap_pkg::path_eval_t           eval;
  logic                          advance;
  logic [dap_pkg::MARGIN_W-1:0]  delay_margin_us;

  assign req_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!req_stall) begin
      item_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      item <= req;
    end
  end

  dap_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .delay_margin_us (delay_margin_us)
  );

  dap_eval u_eval (
    .item            (item),
    .delay_margin_us (delay_margin_us),
    .result          (eval)
  );

  dap_track u_track (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .eval       (eval),
    .advance    (advance),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

### tb/tb_deadline_aware_path_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deadline_aware_path_select
// Self-checking regression for the deadline aware path selector. Path records
// are driven from a queue with random gaps, and every request is folded into a
// running model of the selector. Each result is compared with the oldest
// expected pick. The delay margin is rewritten over APB between phases,
// including 0 and 1000000, and read back. One phase has the receiver hold off
// long enough to back up the input, and one runs with no gaps at all.
// ----------------------------------------------------------------------------
module tb_deadline_aware_path_select;

  localparam int CYCLE_LIMIT = 400000;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       req_valid = 1'b0;
  logic                       req_stall;
  dap_pkg::req_t              req       = '0;
  logic                       rsp_valid;
  logic                       rsp_stall = 1'b0;
  dap_pkg::rsp_t              rsp;
  logic                       psel      = 1'b0;
  logic                       penable   = 1'b0;
  logic                       pwrite    = 1'b0;
  logic [dap_pkg::APB_AW-1:0] paddr     = '0;
  logic [dap_pkg::APB_DW-1:0] pwdata    = '0;
  logic [dap_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  deadline_aware_path_select u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial forever #1 clk = ~clk;

  // selector model state
  logic [dap_pkg::MARGIN_W-1:0] margin_us    = dap_pkg::MARGIN_RESET;
  int                           path_pos     = 0;
  bit                           any_feasible = 1'b0;
  logic [dap_pkg::SCORE_W-1:0]  low_score    = '1;
  logic [dap_pkg::IDX_W-1:0]    best_idx     = '0;
  logic [dap_pkg::RTT_W-1:0]    fastest_rtt  = '0;
  logic [dap_pkg::IDX_W-1:0]    fastest_idx  = '0;

  dap_pkg::req_t pending_records[$];
  dap_pkg::rsp_t expected_picks[$];
  int   n_queued    = 0;
  int   n_taken     = 0;
  int   mismatches  = 0;
  int   idle_pct    = 32;
  int   hold_len    = 0;
  int   hold_reqs   = 0;
  int   hold_seen   = 0;
  int   hold_left   = 0;
  int   cycle_count = 0;

  function automatic bit select_path_step(input dap_pkg::req_t r,
                                          output dap_pkg::rsp_t pick);
    logic [dap_pkg::TIME_W-1:0]  left_us;
    logic [dap_pkg::TIME_W-1:0]  need_us;
    logic [dap_pkg::SCORE_W-1:0] score;
    pick = '0;
    if (path_pos < dap_pkg::MAX_PATHS) begin
      left_us = r.deadline_at_us - r.now_us;
      need_us = dap_pkg::TIME_W'(r.rtt_us >> 1) + dap_pkg::TIME_W'(margin_us);
      if (!r.demoted && r.now_us < r.deadline_at_us && need_us < left_us) begin
        score = {1'b0, r.rtt_us};
        if (r.in_flight_bytes >= r.window_bytes) score = score << 1;
        if (score < low_score) begin
          low_score    = score;
          best_idx     = dap_pkg::IDX_W'(path_pos);
          any_feasible = 1'b1;
        end
      end
      if (path_pos == 0) begin
        fastest_rtt = r.rtt_us;
        fastest_idx = '0;
      end else if (!r.demoted && r.rtt_us < fastest_rtt) begin
        fastest_rtt = r.rtt_us;
        fastest_idx = dap_pkg::IDX_W'(path_pos);
      end
      path_pos++;
    end
    if (!r.last) return 1'b0;
    if (!r.deadline_on || !r.multipath_on) begin
      pick.chosen_path    = '0;
      pick.selection_kind = dap_pkg::KIND_DEFAULT;
    end else if (any_feasible) begin
      pick.chosen_path    = best_idx;
      pick.selection_kind = dap_pkg::KIND_FEASIBLE;
    end else begin
      pick.chosen_path    = fastest_idx;
      pick.selection_kind = dap_pkg::KIND_FALLBACK;
    end
    path_pos     = 0;
    any_feasible = 1'b0;
    low_score    = '1;
    best_idx     = '0;
    fastest_rtt  = '0;
    fastest_idx  = '0;
    return 1'b1;
  endfunction

  // request driver
  always @(posedge clk) begin : drv
    dap_pkg::rsp_t pick;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        n_taken++;
        if (select_path_step(req, pick)) expected_picks.push_back(pick);
      end
      if (!req_valid || !req_stall) begin
        if (pending_records.size() > 0 && $urandom_range(99) >= idle_pct) begin
          req       <= pending_records.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= hold_len;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin : mon
    dap_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_picks.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none, actual path %0d kind %0d",
                 $time, rsp.chosen_path, rsp.selection_kind);
      end else begin
        want = expected_picks.pop_front();
        if (rsp.chosen_path !== want.chosen_path) begin
          mismatches++;
          $display("%0t chosen_path mismatch: expected %0d, actual %0d",
                   $time, want.chosen_path, rsp.chosen_path);
        end
        if (rsp.selection_kind !== want.selection_kind) begin
          mismatches++;
          $display("%0t selection_kind mismatch: expected %0d, actual %0d",
                   $time, want.selection_kind, rsp.selection_kind);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("deadline_aware_path_select regression: fail");
      $finish;
    end
  end

  function automatic dap_pkg::req_t path_rec(input logic [dap_pkg::RTT_W-1:0] rtt,
                                             input logic demoted,
                                             input logic [31:0] flight,
                                             input logic [31:0] win,
                                             input logic [dap_pkg::TIME_W-1:0] now_t,
                                             input logic [dap_pkg::TIME_W-1:0] due_t,
                                             input logic dl_on, input logic mp_on,
                                             input logic last);
    dap_pkg::req_t r;
    r.rtt_us          = rtt;
    r.demoted         = demoted;
    r.in_flight_bytes = flight;
    r.window_bytes    = win;
    r.now_us          = now_t;
    r.deadline_at_us  = due_t;
    r.deadline_on     = dl_on;
    r.multipath_on    = mp_on;
    r.last            = last;
    return r;
  endfunction

  task automatic push_rec(input dap_pkg::req_t r);
    pending_records.push_back(r);
    n_queued++;
  endtask

  task automatic apb_access(input logic wr, input logic [dap_pkg::APB_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= dap_pkg::APB_AW'(dap_pkg::REG_DELAY_MARGIN) << 2;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (wr) begin
      margin_us = data[dap_pkg::MARGIN_W-1:0];
    end else if (prdata !== dap_pkg::APB_DW'(margin_us)) begin
      mismatches++;
      $display("%0t delay_margin_us readback: expected %0d, actual %0d",
               $time, margin_us, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain;
    while (n_taken != n_queued) @(negedge clk);
    while (expected_picks.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic queue_directed;
    logic [dap_pkg::TIME_W-1:0] t0;
    t0 = 64'd1_000_000;
    // single feasible path, then each flag off
    push_rec(path_rec(32'd0, 1'b0, 32'd0, 32'd1, t0, t0 + 100000, 1'b1, 1'b1, 1'b1));
    push_rec(path_rec(32'd500, 1'b0, 32'd0, 32'd1, t0, t0 + 100000, 1'b1, 1'b0, 1'b1));
    push_rec(path_rec(32'd500, 1'b0, 32'd0, 32'd1, t0, t0 + 100000, 1'b0, 1'b1, 1'b1));
    // all paths demoted
    push_rec(path_rec(32'd100, 1'b1, 32'd0, 32'd1, t0, t0 + 100000, 1'b1, 1'b1, 1'b0));
    push_rec(path_rec(32'd50, 1'b1, 32'd0, 32'd1, t0, t0 + 100000, 1'b1, 1'b1, 1'b1));
    // deadline already reached, fastest usable path wins
    push_rec(path_rec(32'd300, 1'b0, 32'd0, 32'd1, t0, t0, 1'b1, 1'b1, 1'b0));
    push_rec(path_rec(32'd200, 1'b1, 32'd0, 32'd1, t0, t0, 1'b1, 1'b1, 1'b0));
    push_rec(path_rec(32'd100, 1'b0, 32'd0, 32'd1, t0, t0, 1'b1, 1'b1, 1'b1));
    // congested path scores double
    push_rec(path_rec(32'd100, 1'b0, 32'd10, 32'd10, t0, t0 + 100000, 1'b1, 1'b1, 1'b0));
    push_rec(path_rec(32'd150, 1'b0, 32'd0, 32'd10, t0, t0 + 100000, 1'b1, 1'b1, 1'b1));
    // tie keeps the earlier path
    push_rec(path_rec(32'd100, 1'b0, 32'd0, 32'd10, t0, t0 + 100000, 1'b1, 1'b1, 1'b0));
    push_rec(path_rec(32'd100, 1'b0, 32'd0, 32'd10, t0, t0 + 100000, 1'b1, 1'b1, 1'b1));
    // need equal to time left is infeasible, one less is feasible
    push_rec(path_rec(32'd2001, 1'b0, 32'd0, 32'd1, t0, t0 + 2000, 1'b1, 1'b1, 1'b0));
    push_rec(path_rec(32'd1999, 1'b0, 32'd0, 32'd1, t0, t0 + 2000, 1'b1, 1'b1, 1'b1));
    // field extremes
    push_rec(path_rec('1, 1'b0, '1, '1, '1, '1, 1'b1, 1'b1, 1'b1));
    push_rec(path_rec('1, 1'b0, '1, '0, '0, '1, 1'b1, 1'b1, 1'b1));
  endtask

  task automatic queue_requests(input int n_items);
    int                         added;
    int                         n_paths;
    int                         pick;
    logic [dap_pkg::TIME_W-1:0] now_t;
    logic [dap_pkg::TIME_W-1:0] slack;
    logic [dap_pkg::TIME_W-1:0] gap;
    logic [dap_pkg::RTT_W-1:0]  rtt;
    logic [31:0]                win;
    logic [31:0]                flight;
    logic                       dl_on;
    logic                       mp_on;
    dap_pkg::req_t              r;
    added = 0;
    while (added < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) n_paths = $urandom_range(17, 20);
      else if (pick < 14) n_paths = dap_pkg::MAX_PATHS;
      else n_paths = $urandom_range(1, 6);
      case ($urandom_range(3))
        0: now_t = dap_pkg::TIME_W'($urandom);
        1: now_t = {$urandom, $urandom};
        2: now_t = '1 - dap_pkg::TIME_W'($urandom_range(0, 1000000));
        default: now_t = '0;
      endcase
      pick = $urandom_range(99);
      if (pick < 70) begin
        slack = dap_pkg::TIME_W'(margin_us) + dap_pkg::TIME_W'($urandom_range(0, 20000));
      end else if (pick < 85) begin
        slack = '0 - dap_pkg::TIME_W'($urandom_range(0, 3));
      end else begin
        slack = {$urandom, $urandom};
      end
      dl_on = ($urandom_range(9) != 0);
      mp_on = ($urandom_range(9) != 0);
      for (int k = 0; k < n_paths; k++) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          rtt = $urandom_range(0, 30000);
        end else if (pick < 75) begin
          rtt = $urandom;
        end else if (pick < 80) begin
          rtt = '1;
        end else if (pick < 85) begin
          rtt = '0;
        end else begin
          // land right at the feasibility boundary
          gap = slack - dap_pkg::TIME_W'(margin_us) -
                dap_pkg::TIME_W'($urandom_range(0, 1));
          rtt = {gap[30:0], 1'($urandom_range(0, 1))};
        end
        win = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 65535);
        case ($urandom_range(3))
          0: flight = win;
          1: flight = win + 1;
          2: flight = win - 1;
          default: flight = $urandom;
        endcase
        r = path_rec(rtt, ($urandom_range(99) < 25), flight, win, now_t, now_t + slack,
                     dl_on, mp_on, (k == n_paths - 1));
        if ($urandom_range(99) < 10) begin
          r.now_us         = {$urandom, $urandom};
          r.deadline_at_us = {$urandom, $urandom};
          r.deadline_on    = 1'($urandom_range(0, 1));
          r.multipath_on   = 1'($urandom_range(0, 1));
        end
        push_rec(r);
        added++;
      end
    end
  endtask

  initial begin : main
    logic [dap_pkg::APB_DW-1:0] margins[5];
    margins = '{dap_pkg::APB_DW'(0), dap_pkg::APB_DW'(1000000),
                dap_pkg::APB_DW'($urandom_range(1, 999999)),
                dap_pkg::APB_DW'(1), dap_pkg::APB_DW'(dap_pkg::MARGIN_RESET)};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    apb_access(1'b0, '0);
    queue_directed();
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      apb_access(1'b1, margins[ph]);
      apb_access(1'b0, '0);
      idle_pct = (ph == 2) ? 0 : 32;
      queue_requests(160);
      if (ph == 1) begin
        hold_len = 300;
        hold_reqs++;
      end
      drain();
    end
    if (mismatches == 0) begin
      $display("deadline_aware_path_select regression: pass");
    end else begin
      $display("deadline_aware_path_select regression: fail");
    end
    $finish;
  end

endmodule
